// ===== src/packed_mono_framebuffer_writer_assert.svh =====
// Assertion macros for the packed mono frame buffer writer.
`ifndef PACKED_MONO_FRAMEBUFFER_WRITER_ASSERT_SVH
`define PACKED_MONO_FRAMEBUFFER_WRITER_ASSERT_SVH

// Check that cond implies expr in the same cycle.
`define PMFB_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Check that cond implies expr in the next cycle.
`define PMFB_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== src/pmfb_pkg.sv =====
// Package with codes, widths and constants of the packed mono frame buffer writer.
`timescale 1ns / 1ps

package pmfb_pkg;

	localparam int COORD_W   = 10;
	localparam int RIDX_W    = 14;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 17;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 10;

	// Request kinds carried on the input tuser bit
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Orientation codes
	localparam logic ORIENT_PORTRAIT  = 1'b0;
	localparam logic ORIENT_LANDSCAPE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

	// Register reset values
	localparam logic [COORD_W-1:0] WIDTH_RESET  = 10'd400;
	localparam logic [COORD_W-1:0] HEIGHT_RESET = 10'd300;

	// Mask of the leftmost bit of a byte; lower bits sit further right
	localparam logic [BYTE_W-1:0] TOP_BIT = 8'h80;

endpackage

// ===== src/pmfb_store.sv =====
// Byte store with one write port, one registered read port and a clearing sweep after reset.
`timescale 1ns / 1ps

module pmfb_store #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [pmfb_pkg::BYTE_W-1:0] rd_data,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [pmfb_pkg::BYTE_W-1:0] wr_data,
	output logic                      clr_busy
);
	import pmfb_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [AW-1:0]     clr_cnt_q;
	logic              clr_busy_q;
	logic              we;
	logic [AW-1:0]     wa;
	logic [BYTE_W-1:0] wd;

	// Sweep every entry to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_cnt_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	// Give the sweep the write port while it runs
	always_comb begin
		we = clr_busy_q | wr_en;
		wa = clr_busy_q ? clr_cnt_q : wr_addr;
		wd = clr_busy_q ? '0 : wr_data;
	end

	// Write, and read through a registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

// ===== src/packed_mono_framebuffer_writer.sv =====
// Top level of the packed mono frame buffer writer: request pipeline and configuration.
`timescale 1ns / 1ps
`include "packed_mono_framebuffer_writer_assert.svh"

// One-bit-per-pixel frame store with swizzled pixel placement.
// Input beats (s_*): tuser selects a pixel write or a byte read; tdata carries
// the pixel coordinates, the pixel value and the read index. Every input beat
// yields exactly one output beat (m_*): the byte read (zero for a write) in
// tdata and an out-of-range flag in tuser. Out-of-range writes leave the store
// untouched.
// Path: an accepted beat moves through stage 1, stage 2 and stage 3 into the output
// register. Throughput: one beat per cycle while no stall holds the pipeline, set
// by the single read-modify-write path through the store; a write followed at once by a
// beat to the same byte takes its data from a forwarding register.
// Reset: the store is swept to zero one byte a cycle, over all STORE_BYTES bytes, with
// s_tready low; configuration writes are taken during the sweep. Registers
// reset to landscape, 400 by 300.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds and
// s_tready is low; no store write happens during a stall.
// Configuration: cfg_we writes cfg_wdata to cfg_index (0 orientation, 1 frame width, 2
// frame height); the user must write only while no request is in flight; not enforced.
module packed_mono_framebuffer_writer #(
	parameter int STORE_BYTES = 16384
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [9:0] pixel_x, [19:10] pixel_y, [20] pixel_on, [34:21] read_index, rest zero
	input  logic [pmfb_pkg::S_TDATA_W-1:0]      s_tdata,
	// [0] req_type
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] read_byte
	output logic [pmfb_pkg::M_TDATA_W-1:0]      m_tdata,
	// [0] status
	output logic                                m_tuser,
	input  logic                                cfg_we,
	input  logic [pmfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmfb_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import pmfb_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	// Configuration
	logic               orientation_q;
	logic [COORD_W-1:0] frame_width_q;
	logic [COORD_W-1:0] frame_height_q;
	logic [IDX_W-1:0]   frame_bytes_q;

	// Input fields
	logic               req_in;
	logic [COORD_W-1:0] x_in;
	logic [COORD_W-1:0] y_in;
	logic               on_in;
	logic [RIDX_W-1:0]  ridx_in;

	// Address setup
	logic               in_frame;
	logic [COORD_W-1:0] iy;
	logic [8:0]         mul_a;
	logic [7:0]         mul_b;
	logic [7:0]         add_c;
	logic [2:0]         bit_sel;

	logic               adv;
	logic               clr_busy;

	// Stage 1
	logic               valid_s1;
	logic               req_s1;
	logic               on_s1;
	logic [RIDX_W-1:0]  ridx_s1;
	logic               in_frame_s1;
	logic [8:0]         mul_a_s1;
	logic [7:0]         mul_b_s1;
	logic [7:0]         add_c_s1;
	logic [BYTE_W-1:0]  mask_s1;

	// Stage 2
	logic               valid_s2;
	logic               req_s2;
	logic               on_s2;
	logic [RIDX_W-1:0]  ridx_s2;
	logic               in_frame_s2;
	logic [IDX_W-1:0]   prod_s2;
	logic [7:0]         add_c_s2;
	logic [BYTE_W-1:0]  mask_s2;
	logic [IDX_W-1:0]   pix_idx;
	logic [IDX_W-1:0]   addr_full;
	logic               ok_s2;

	// Stage 3
	logic               valid_s3;
	logic               req_s3;
	logic               on_s3;
	logic               ok_s3;
	logic [AW-1:0]      addr_s3;
	logic [BYTE_W-1:0]  mask_s3;
	logic [BYTE_W-1:0]  rd_data;
	logic [BYTE_W-1:0]  base_byte;
	logic [BYTE_W-1:0]  new_byte;
	logic               wr_pipe;

	// Forwarding of the latest store write
	logic               fwd_valid_q;
	logic [AW-1:0]      fwd_addr_q;
	logic [BYTE_W-1:0]  fwd_data_q;

	// Output register
	logic               m_tvalid_q;
	logic [BYTE_W-1:0]  m_tdata_q;
	logic               m_tuser_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orientation_q  <= ORIENT_LANDSCAPE;
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIENTATION:  orientation_q  <= cfg_wdata[0];
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Frame size in bytes, for the read range check
	always_ff @(posedge clk) begin
		frame_bytes_q <= IDX_W'((20'(frame_width_q) * 20'(frame_height_q)) >> 3);
	end

	// Unpack the input beat
	always_comb begin
		req_in  = s_tuser;
		x_in    = s_tdata[9:0];
		y_in    = s_tdata[19:10];
		on_in   = s_tdata[20];
		ridx_in = s_tdata[34:21];
	end

	// Pick the tile multiply operands and the bit within the byte
	always_comb begin
		in_frame = (x_in < frame_width_q) && (y_in < frame_height_q);
		iy       = frame_height_q - 10'd1 - y_in;
		case (orientation_q)
			ORIENT_PORTRAIT: begin
				mul_a   = y_in[9:1];
				mul_b   = frame_width_q[9:2];
				add_c   = x_in[9:2];
				bit_sel = {x_in[1:0], y_in[0]};
			end
			default: begin
				mul_a   = x_in[9:1];
				mul_b   = frame_height_q[9:2];
				add_c   = iy[9:2];
				bit_sel = {iy[1:0], x_in[0]};
			end
		endcase
	end

	// Advance the whole pipeline unless the output holds a beat not yet taken
	assign adv      = !m_tvalid_q || m_tready;
	assign s_tready = adv && !clr_busy;

	// Pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			valid_s1   <= s_tvalid && !clr_busy;
			valid_s2   <= valid_s1;
			valid_s3   <= valid_s2;
			m_tvalid_q <= valid_s3;
		end
	end

	// Stage 1: capture request and multiply operands
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1      <= req_in;
			on_s1       <= on_in;
			ridx_s1     <= ridx_in;
			in_frame_s1 <= in_frame;
			mul_a_s1    <= mul_a;
			mul_b_s1    <= mul_b;
			add_c_s1    <= add_c;
			mask_s1     <= TOP_BIT >> bit_sel;
		end
	end

	// Stage 2: register the tile product
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2      <= req_s1;
			on_s2       <= on_s1;
			ridx_s2     <= ridx_s1;
			in_frame_s2 <= in_frame_s1;
			prod_s2     <= IDX_W'(mul_a_s1 * mul_b_s1);
			add_c_s2    <= add_c_s1;
			mask_s2     <= mask_s1;
		end
	end

	// Form the byte index and check its range
	always_comb begin
		pix_idx = prod_s2 + IDX_W'(add_c_s2);
		if (req_s2 == REQ_READ) begin
			addr_full = IDX_W'(ridx_s2);
			ok_s2     = (IDX_W'(ridx_s2) < frame_bytes_q) &&
			            (32'(ridx_s2) < 32'(STORE_BYTES));
		end else begin
			addr_full = pix_idx;
			ok_s2     = in_frame_s2 && (32'(pix_idx) < 32'(STORE_BYTES));
		end
	end

	// Stage 3: store read data arrives here
	always_ff @(posedge clk) begin
		if (adv) begin
			req_s3  <= req_s2;
			on_s3   <= on_s2;
			ok_s3   <= ok_s2;
			addr_s3 <= addr_full[AW-1:0];
			mask_s3 <= mask_s2;
		end
	end

	// Merge the pixel into the byte; take the previous write's data if it raced the read
	always_comb begin
		base_byte = (fwd_valid_q && fwd_addr_q == addr_s3) ? fwd_data_q : rd_data;
		new_byte  = on_s3 ? (base_byte | mask_s3) : (base_byte & ~mask_s3);
		wr_pipe   = adv && valid_s3 && ok_s3 && (req_s3 == REQ_WRITE);
	end

	// Remember the latest store write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_pipe) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_pipe) begin
			fwd_addr_q <= addr_s3;
			fwd_data_q <= new_byte;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= (req_s3 == REQ_READ && ok_s3) ? base_byte : '0;
			m_tuser_q <= !ok_s3;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	pmfb_store #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (adv && valid_s2 && ok_s2),
		.rd_addr  (addr_full[AW-1:0]),
		.rd_data  (rd_data),
		.wr_en    (wr_pipe),
		.wr_addr  (addr_s3),
		.wr_data  (new_byte),
		.clr_busy (clr_busy)
	);

	`PMFB_ASSERT_NOW(a_no_accept_in_sweep, clr_busy, !s_tready, "beat accepted during clear sweep")
	`PMFB_ASSERT_NOW(a_no_write_in_stall, m_tvalid && !m_tready, !wr_pipe, "store write while stalled")
	`PMFB_ASSERT_NOW(a_no_write_in_sweep, wr_pipe, !clr_busy, "pipeline write during clear sweep")
	`PMFB_ASSERT_NEXT(a_write_zero_byte, adv && valid_s3 && req_s3 == REQ_WRITE, m_tdata == '0, "nonzero byte on a write result")

endmodule

// ===== tb/sv/pmfb_result_checker.sv =====
// Scoreboard for the packed mono frame buffer writer: pixel store model and beat comparison.
`timescale 1ns / 1ps

module pmfb_result_checker #(
	parameter int STORE_BYTES = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// [9:0] pixel_x, [19:10] pixel_y, [20] pixel_on, [34:21] read_index, rest zero
	input  logic [pmfb_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] req_type
	input  logic                            s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// [7:0] read_byte
	input  logic [pmfb_pkg::M_TDATA_W-1:0]  m_tdata,
	// [0] status
	input  logic                            m_tuser,
	input  logic                            cfg_we,
	input  logic [pmfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pmfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              mismatches,
	output int                              outstanding
);
	import pmfb_pkg::*;

	localparam int MAX_REPORTS = 10;
	// Low bits that select the position inside a tile
	localparam int TILE_MOD4_MASK = 'h03;
	localparam int TILE_MOD2_MASK = 'h01;

	typedef struct packed {
		logic [BYTE_W-1:0] read_byte;
		logic              status;
	} pixel_result_t;

	logic [BYTE_W-1:0]  pixel_store [0:STORE_BYTES-1];
	logic               layout;
	logic [COORD_W-1:0] frame_w;
	logic [COORD_W-1:0] frame_h;
	pixel_result_t      pending_results [$];
	pixel_result_t      predicted;
	pixel_result_t      oldest;
	int                 error_count;
	int                 k;

	// Apply one request to the store copy and return the beat it should produce
	function automatic pixel_result_t apply_request(input logic req, input logic [COORD_W-1:0] px,
		input logic [COORD_W-1:0] py, input logic on, input logic [RIDX_W-1:0] ridx);
		int x;
		int y;
		int w;
		int h;
		int iy;
		int byte_idx;
		int shift;
		int frame_bytes;
		logic [BYTE_W-1:0] mask;
		pixel_result_t r;
		x = px;
		y = py;
		w = frame_w;
		h = frame_h;
		r.read_byte = '0;
		r.status = 1'b0;
		if (req == REQ_WRITE) begin
			if (x >= w || y >= h) begin
				r.status = 1'b1;
			end else begin
				if (layout == ORIENT_PORTRAIT) begin
					byte_idx = (y >> 1) * (w >> 2) + (x >> 2);
					shift = ((x & TILE_MOD4_MASK) << 1) | (y & TILE_MOD2_MASK);
				end else begin
					iy = h - 1 - y;
					byte_idx = (x >> 1) * (h >> 2) + (iy >> 2);
					shift = ((iy & TILE_MOD4_MASK) << 1) | (x & TILE_MOD2_MASK);
				end
				mask = TOP_BIT >> shift;
				if (byte_idx >= STORE_BYTES)
					r.status = 1'b1;
				else if (on)
					pixel_store[byte_idx] = pixel_store[byte_idx] | mask;
				else
					pixel_store[byte_idx] = pixel_store[byte_idx] & ~mask;
			end
		end else begin
			frame_bytes = (w * h) >> 3;
			if (ridx >= frame_bytes || ridx >= STORE_BYTES)
				r.status = 1'b1;
			else
				r.read_byte = pixel_store[ridx];
		end
		return r;
	endfunction

	// Track registers, predict on every input beat, compare every output beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (k = 0; k < STORE_BYTES; k++)
				pixel_store[k] = '0;
			layout = ORIENT_LANDSCAPE;
			frame_w = WIDTH_RESET;
			frame_h = HEIGHT_RESET;
			pending_results.delete();
			error_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_ORIENTATION:  layout = cfg_wdata[0];
					CFG_FRAME_WIDTH:  frame_w = cfg_wdata[COORD_W-1:0];
					CFG_FRAME_HEIGHT: frame_h = cfg_wdata[COORD_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predicted = apply_request(s_tuser, s_tdata[9:0], s_tdata[19:10], s_tdata[20],
					s_tdata[34:21]);
				pending_results.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected output beat: byte %h status %b", m_tdata, m_tuser);
				end else begin
					oldest = pending_results.pop_front();
					if (oldest.read_byte !== m_tdata || oldest.status !== m_tuser) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("mismatch: expected byte %h status %b, got byte %h status %b",
								oldest.read_byte, oldest.status, m_tdata, m_tuser);
					end
				end
			end
			mismatches <= error_count;
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== tb/sv/tb_packed_mono_framebuffer_writer.sv =====
// Testbench top for the packed mono frame buffer writer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_packed_mono_framebuffer_writer;
	import pmfb_pkg::*;

	localparam int STORE_BYTES     = 16384;
	localparam int WATCHDOG_LIMIT  = 100000;
	localparam int PRESSURE_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 8;
	localparam int TDATA_PAD       = S_TDATA_W - (2 * COORD_W + 1 + RIDX_W);

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;
	logic                  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int                    mismatches;
	int                    outstanding;
	int                    sender_idle_pct;
	int                    receiver_stall_pct;
	bit                    pressure_req;
	bit                    pressure_done;
	int                    cur_w;
	int                    cur_h;
	logic [COORD_W-1:0]    last_x;
	logic [COORD_W-1:0]    last_y;
	int                    quiet_cycles;

	packed_mono_framebuffer_writer #(
		.STORE_BYTES(STORE_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	pmfb_result_checker #(
		.STORE_BYTES(STORE_BYTES)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output side: random stalls, plus one long hold-off on request
	initial begin
		m_tready = 1'b0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_req && !pressure_done) begin
				pressure_done = 1'b1;
				m_tready <= 1'b0;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	// End the run when no beat moves for too long
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Offer one request beat and hold it until the block takes it
	task automatic send_request(input logic rt, input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y, input logic on, input logic [RIDX_W-1:0] ridx);
		bit ready_seen;
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= rt;
		s_tdata <= {{TDATA_PAD{1'b0}}, ridx, on, y, x};
		ready_seen = 1'b0;
		while (!ready_seen) begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end
	endtask

	// Mostly in-frame writes and in-range reads, some neighbors and noise
	task automatic send_random(input int count);
		int pick;
		int span;
		logic rt;
		logic on;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [RIDX_W-1:0] ridx;
		repeat (count) begin
			pick = $urandom_range(99);
			rt = REQ_WRITE;
			x = COORD_W'($urandom_range(1023));
			y = COORD_W'($urandom_range(1023));
			ridx = RIDX_W'($urandom_range(16383));
			on = 1'($urandom_range(1));
			span = (cur_w * cur_h) >> 3;
			if (span > STORE_BYTES)
				span = STORE_BYTES;
			if (pick < 45) begin
				if (cur_w > 0 && cur_h > 0) begin
					x = COORD_W'($urandom_range(cur_w - 1));
					y = COORD_W'($urandom_range(cur_h - 1));
				end
			end else if (pick < 55) begin
				// hit the same byte as the last write
				x = last_x ^ 10'd1;
				y = last_y;
			end else if (pick < 80) begin
				rt = REQ_READ;
				if (span > 0)
					ridx = RIDX_W'($urandom_range(span - 1));
			end else if (pick >= 90) begin
				rt = REQ_READ;
			end
			if (rt == REQ_WRITE) begin
				last_x = x;
				last_y = y;
			end
			send_request(rt, x, y, on, ridx);
		end
	endtask

	// Write all three registers and set the idling mix for the next stretch
	task automatic begin_phase(input logic orient, input int w, input int h,
		input int idle_pct, input int stall_pct);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ORIENTATION;
		cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, orient};
		@(posedge clk);
		cfg_index <= CFG_FRAME_WIDTH;
		cfg_wdata <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= CFG_FRAME_HEIGHT;
		cfg_wdata <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_w = w;
		cur_h = h;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// Stop offering and wait until every result has come out
	task automatic end_phase();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_WRITE;
		cfg_we = 1'b0;
		cfg_index = CFG_ORIENTATION;
		cfg_wdata = '0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		pressure_req = 1'b0;
		cur_w = WIDTH_RESET;
		cur_h = HEIGHT_RESET;
		last_x = '0;
		last_y = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset layout: landscape 400 by 300, corners, edges, out of range
		send_request(REQ_WRITE, 10'd0, 10'd0, 1'b1, 14'd0);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd74);
		send_request(REQ_WRITE, 10'd1, 10'd0, 1'b1, 14'd16383);
		send_request(REQ_READ, 10'd1023, 10'd1023, 1'b1, 14'd74);
		send_request(REQ_WRITE, 10'd399, 10'd299, 1'b1, 14'd0);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd14925);
		send_request(REQ_WRITE, 10'd400, 10'd0, 1'b1, 14'd0);
		send_request(REQ_WRITE, 10'd0, 10'd300, 1'b1, 14'd0);
		send_request(REQ_WRITE, 10'd1023, 10'd1023, 1'b1, 14'd16383);
		send_request(REQ_WRITE, 10'd0, 10'd0, 1'b0, 14'd0);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd74);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd14999);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd15000);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd16383);
		send_request(REQ_WRITE, 10'd200, 10'd150, 1'b0, 14'd0);
		end_phase();

		// Portrait at full panel size
		begin_phase(ORIENT_PORTRAIT, 400, 300, 0, 0);
		send_request(REQ_WRITE, 10'd0, 10'd0, 1'b1, 14'd0);
		send_request(REQ_WRITE, 10'd3, 10'd1, 1'b1, 14'd0);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd0);
		send_request(REQ_WRITE, 10'd399, 10'd299, 1'b1, 14'd0);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd14999);
		send_random(200);
		end_phase();

		// Frames too large for the store
		begin_phase(ORIENT_LANDSCAPE, 1020, 1020, 49, 0);
		send_random(150);
		end_phase();

		begin_phase(ORIENT_PORTRAIT, 1023, 1023, 0, 49);
		send_request(REQ_WRITE, 10'd1022, 10'd1022, 1'b1, 14'd0);
		send_request(REQ_WRITE, 10'd0, 10'd0, 1'b1, 14'd0);
		send_request(REQ_READ, 10'd0, 10'd0, 1'b0, 14'd0);
		send_random(150);
		end_phase();

		// Four by four frame: every write lands in one of two bytes
		begin_phase(ORIENT_LANDSCAPE, 4, 4, 13, 13);
		send_random(200);
		end_phase();

		// Long output hold-off so the pipeline fills and backs up
		begin_phase(ORIENT_PORTRAIT, 8, 4, 0, 49);
		pressure_req = 1'b1;
		send_random(200);
		end_phase();

		// Dimensions that are not multiples of four
		begin_phase(ORIENT_LANDSCAPE, 6, 10, 49, 0);
		send_random(150);
		end_phase();

		// Zero height rejects every write and every read
		begin_phase(ORIENT_PORTRAIT, 2, 0, 13, 13);
		send_random(100);
		end_phase();

		begin_phase(ORIENT_LANDSCAPE, 3, 5, 0, 0);
		send_random(100);
		end_phase();

		begin_phase(ORIENT_PORTRAIT, 64, 32, 13, 13);
		send_random(200);
		end_phase();

		begin_phase(ORIENT_LANDSCAPE, 400, 300, 0, 49);
		send_random(100);
		end_phase();

		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/pmfb_pkg.sv
src/pmfb_store.sv
src/packed_mono_framebuffer_writer.sv
tb/sv/pmfb_result_checker.sv
tb/sv/tb_packed_mono_framebuffer_writer.sv
